// ===== hw/rtl/igjh_pkg.sv =====
// Shared types and constants of the intensity-gradient joint histogram.
package igjh_pkg;

  // Item kinds carried on in_tuser.
  localparam logic [1:0] OP_ACCUM  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_INT_MIN  = 2'd0;
  localparam logic [1:0] REG_INT_MAX  = 2'd1;
  localparam logic [1:0] REG_GRAD_MIN = 2'd2;
  localparam logic [1:0] REG_GRAD_MAX = 2'd3;

  // Fixed-point constants of the shade path.
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [4:0]  LOG_LAST   = 5'd23;
  localparam logic [4:0]  SER_LAST   = 5'd24;
  localparam logic [5:0]  K_LIMIT    = 6'd6;
  localparam logic [7:0]  SHADE_FULL = 8'd255;

  // Controller states.
  typedef enum logic [4:0] {
    ST_CLEAR, ST_CLR_INIT, ST_IDLE, ST_BIN_CHK, ST_BIN_WAIT, ST_ACC_UPD,
    ST_RD_ISSUE, ST_RD_CAP, ST_NORM_A, ST_LOG_A, ST_LOAD_B, ST_NORM_B, ST_LOG_B,
    ST_RATIO_START, ST_RATIO_WAIT, ST_K_CHK, ST_SER_INIT_E, ST_SER_MUL,
    ST_SER_DIV, ST_SER_WAIT, ST_POW, ST_DONE
  } ctl_state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_CLR_INIT, DP_CLR_STEP, DP_BIN_START, DP_ACC_RD,
    DP_ACC_UPD, DP_RD_ISSUE, DP_RD_CAP, DP_NORM_STEP, DP_LOG_INIT, DP_LOG_STEP,
    DP_NORM_INIT_B, DP_RATIO_START, DP_RATIO_CAP, DP_SHADE_SAT, DP_SER_INIT,
    DP_SER_MUL, DP_SER_DIV, DP_SER_ACC, DP_POW_STEP, DP_FIN, DP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel;   // second operand of a log or series pass
  } cmd_t;

  typedef struct packed {
    logic bin_ok;
    logic bin_busy;
    logic rd_ok;
    logic m2_zero;
    logic norm_done;
    logic log_last;
    logic div_busy;
    logic k_big;
    logic ser_last;
    logic pow_done;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/igjh_ram.sv =====
// Generic single-port RAM with registered read.
module igjh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read at the same address; read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/igjh_div.sv =====
// Restoring divider, one quotient bit per cycle.
module igjh_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [Q_W-1:0]   quo
);

  localparam int CW  = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int CNW = $clog2(Q_W + 1);

  logic [CW-1:0]  rem_r;
  logic [CW-1:0]  dsh_r;
  logic [Q_W-1:0] quo_r;
  logic [CNW-1:0] cnt_r;
  logic           fit;

  // The quotient is known to stay below 2**Q_W.
  assign fit  = rem_r >= dsh_r;
  assign busy = cnt_r != '0;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNW'(Q_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Shift the divisor down one place a step and subtract where it fits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= CW'(num);
      dsh_r <= CW'(den) << (Q_W - 1);
      quo_r <= '0;
    end else if (busy) begin
      if (fit) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[Q_W-2:0], fit};
      dsh_r <= dsh_r >> 1;
    end
  end

endmodule

// ===== hw/rtl/igjh_dp.sv =====
// Datapath: configuration, binning, count store, maxima and shade arithmetic.
module igjh_dp
  import igjh_pkg::*;
#(
  parameter int BINS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [47:0] in_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata
);

  localparam int QW    = $clog2(BINS);
  localparam int DEPTH = BINS * BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BNW   = QW + 16;

  // Configuration registers.
  logic [15:0] int_min_r, int_max_r, grad_min_r, grad_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_min_r  <= 16'd0;
      int_max_r  <= 16'd32767;
      grad_min_r <= 16'd0;
      grad_max_r <= 16'd65535;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INT_MIN:  int_min_r  <= cfg_wdata;
        REG_INT_MAX:  int_max_r  <= cfg_wdata;
        REG_GRAD_MIN: grad_min_r <= cfg_wdata;
        REG_GRAD_MAX: grad_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Captured input word.
  logic [15:0] iv_r, gv_r;
  logic [7:0]  rg_r, ri_r;

  // Offset and span per axis, folded so that the span is positive.
  logic signed [17:0] ia, id, ga, gd, iaf, idf, gaf, gdf;
  logic               i_ok, g_ok;

  always_comb begin
    ia = $signed({{2{iv_r[15]}}, iv_r}) - $signed({{2{int_min_r[15]}}, int_min_r});
    id = $signed({{2{int_max_r[15]}}, int_max_r}) - $signed({{2{int_min_r[15]}}, int_min_r});
    ga = $signed({2'b00, gv_r}) - $signed({2'b00, grad_min_r});
    gd = $signed({2'b00, grad_max_r}) - $signed({2'b00, grad_min_r});
    iaf = id[17] ? -ia : ia;
    idf = id[17] ? -id : id;
    gaf = gd[17] ? -ga : ga;
    gdf = gd[17] ? -gd : gd;
    i_ok = (idf != '0) && !iaf[17] && (iaf < idf);
    g_ok = (gdf != '0) && !gaf[17] && (gaf < gdf);
  end

  // Bin dividers, one per axis.
  logic          bin_start;
  logic          ib_busy, gb_busy;
  logic [QW-1:0] iq, gq;
  logic [BNW-1:0] inum, gnum;

  assign bin_start = cmd.op == DP_BIN_START;
  assign inum = BNW'(32'(iaf[15:0]) * BINS);
  assign gnum = BNW'(32'(gaf[15:0]) * BINS);

  igjh_div #(.NUM_W(BNW), .DEN_W(16), .Q_W(QW)) u_div_int (
    .clk(clk), .rst_n(rst_n), .start(bin_start), .num(inum), .den(idf[15:0]),
    .busy(ib_busy), .quo(iq)
  );

  igjh_div #(.NUM_W(BNW), .DEN_W(16), .Q_W(QW)) u_div_grad (
    .clk(clk), .rst_n(rst_n), .start(bin_start), .num(gnum), .den(gdf[15:0]),
    .busy(gb_busy), .quo(gq)
  );

  // Count store and its address selection.
  logic [AW-1:0] clr_addr_r, addr_r, acc_addr, rd_addr, mem_addr;
  logic          mem_we;
  logic [31:0]   mem_wdata, mem_rdata, c_inc;
  logic          c_sat;

  assign acc_addr = AW'(32'(gq) * BINS + 32'(iq));
  assign rd_addr  = AW'(32'(rg_r) * BINS + 32'(ri_r));
  assign c_sat    = &mem_rdata;
  assign c_inc    = mem_rdata + 32'd1;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_r;
    mem_wdata = c_inc;
    case (cmd.op)
      DP_CLR_STEP: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      DP_ACC_RD:   mem_addr = acc_addr;
      DP_ACC_UPD:  mem_we = !c_sat;
      DP_RD_ISSUE: mem_addr = rd_addr;
      default: ;
    endcase
  end

  igjh_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // Shade arithmetic registers.
  logic [32:0] x_r;
  logic [5:0]  sh_r;
  logic [30:0] m_r;
  logic [29:0] res_r, l1_r, l2_r;
  logic [4:0]  cnt_r;
  logic [35:0] r_r;
  logic [30:0] f_r, term_r, pr_r, e_r, e1_r;
  logic signed [33:0] sum_r;
  logic [4:0]  n_r;
  logic [2:0]  j_r;

  // One multiplier shared by the log, series and power steps.
  logic [30:0] mul_a, mul_b;
  logic [61:0] prod;
  logic [31:0] sq;

  always_comb begin
    case (cmd.op)
      DP_SER_MUL:  begin mul_a = term_r; mul_b = f_r;  end
      DP_POW_STEP: begin mul_a = e_r;    mul_b = e1_r; end
      default:     begin mul_a = m_r;    mul_b = m_r;  end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign sq   = prod[61:30];

  // Shared divider for the log ratio and the series terms.
  logic        sd_start, sd_busy;
  logic [59:0] sd_num;
  logic [29:0] sd_den;
  logic [35:0] sd_quo;

  assign sd_start = (cmd.op == DP_RATIO_START) || (cmd.op == DP_SER_DIV);
  assign sd_num   = (cmd.op == DP_RATIO_START) ? {l1_r, 30'd0} : 60'(pr_r);
  assign sd_den   = (cmd.op == DP_RATIO_START) ? l2_r : 30'(n_r);

  igjh_div #(.NUM_W(60), .DEN_W(30), .Q_W(36)) u_div_shade (
    .clk(clk), .rst_n(rst_n), .start(sd_start), .num(sd_num), .den(sd_den),
    .busy(sd_busy), .quo(sd_quo)
  );

  // Series accumulation and the final grey level.
  logic signed [33:0] sum_nxt;
  logic [30:0]        e_nxt;
  logic [29:0]        res_nxt;
  logic [30:0]        diff;
  logic [8:0]         v;

  always_comb begin
    sum_nxt = n_r[0] ? sum_r - $signed(34'(sd_quo[30:0]))
                     : sum_r + $signed(34'(sd_quo[30:0]));
    e_nxt   = sum_nxt[33] ? '0 : sum_nxt[30:0];
    res_nxt = res_r;
    res_nxt[LOG_LAST - cnt_r] = sq[31];
    diff    = Q30_ONE - e_r;
    v       = diff[30:22];
  end

  // Tracked maxima and result fields.
  logic [31:0]   top_r, runner_r, count_r;
  logic [AW-1:0] top_bin_r;
  logic          acc_r;
  logic [7:0]    shade_r;
  logic          out_valid_r;
  logic [79:0]   out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      top_r      <= '0;
      runner_r   <= '0;
      top_bin_r  <= '0;
    end else begin
      case (cmd.op)
        DP_CLR_INIT: begin
          clr_addr_r <= '0;
          top_r      <= '0;
          runner_r   <= '0;
          top_bin_r  <= '0;
        end
        DP_CLR_STEP: clr_addr_r <= clr_addr_r + 1'b1;
        DP_ACC_UPD: begin
          if (!c_sat) begin
            if (addr_r == top_bin_r) begin
              top_r <= c_inc;
            end else if (c_inc > top_r) begin
              runner_r  <= top_r;
              top_r     <= c_inc;
              top_bin_r <= addr_r;
            end else if (c_inc > runner_r) begin
              runner_r <= c_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Item work registers, stepped by the controller.
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        iv_r    <= in_tdata[15:0];
        gv_r    <= in_tdata[31:16];
        rg_r    <= in_tdata[39:32];
        ri_r    <= in_tdata[47:40];
        acc_r   <= 1'b0;
        count_r <= '0;
        shade_r <= '0;
      end
      DP_ACC_RD:  addr_r <= acc_addr;
      DP_ACC_UPD: acc_r <= 1'b1;
      DP_RD_CAP: begin
        count_r <= mem_rdata;
        shade_r <= (mem_rdata != '0) ? SHADE_FULL : '0;
        x_r     <= {1'b0, mem_rdata} + 33'd1;
        sh_r    <= '0;
      end
      DP_NORM_INIT_B: begin
        x_r  <= {1'b0, runner_r} + 33'd1;
        sh_r <= '0;
      end
      DP_NORM_STEP: begin
        x_r  <= x_r << 1;
        sh_r <= sh_r + 1'b1;
      end
      DP_LOG_INIT: begin
        m_r   <= x_r[32:2];
        res_r <= 30'(6'd32 - sh_r) << 24;
        cnt_r <= '0;
      end
      DP_LOG_STEP: begin
        m_r   <= sq[31] ? sq[31:1] : sq[30:0];
        res_r <= res_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LOG_LAST) begin
          if (cmd.sel) begin
            l2_r <= res_nxt;
          end else begin
            l1_r <= res_nxt;
          end
        end
      end
      DP_RATIO_CAP: r_r <= sd_quo;
      DP_SHADE_SAT: shade_r <= SHADE_FULL;
      DP_SER_INIT: begin
        f_r    <= cmd.sel ? {1'b0, r_r[29:0]} : Q30_ONE;
        term_r <= Q30_ONE;
        sum_r  <= 34'(Q30_ONE);
        n_r    <= 5'd1;
        j_r    <= '0;
      end
      DP_SER_MUL: pr_r <= prod[60:30];
      DP_SER_ACC: begin
        term_r <= sd_quo[30:0];
        sum_r  <= sum_nxt;
        n_r    <= n_r + 1'b1;
        if (n_r == SER_LAST) begin
          if (cmd.sel) begin
            e_r <= e_nxt;
          end else begin
            e1_r <= e_nxt;
          end
        end
      end
      DP_POW_STEP: begin
        e_r <= prod[60:30];
        j_r <= j_r + 1'b1;
      end
      DP_FIN: begin
        if (e_r >= Q30_ONE) begin
          shade_r <= '0;
        end else begin
          shade_r <= v[8] ? SHADE_FULL : v[7:0];
        end
      end
      default: ;
    endcase
  end

  // Output register parts the result side from the work in progress.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_OUT_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT_LOAD) begin
      out_data_r <= {7'd0, runner_r, shade_r, count_r, acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller.
  always_comb begin
    stat.bin_ok    = i_ok && g_ok;
    stat.bin_busy  = ib_busy || gb_busy;
    stat.rd_ok     = (32'(rg_r) < BINS) && (32'(ri_r) < BINS);
    stat.m2_zero   = runner_r == '0;
    stat.norm_done = x_r[32];
    stat.log_last  = cnt_r == LOG_LAST;
    stat.div_busy  = sd_busy;
    stat.k_big     = r_r[35:30] >= K_LIMIT;
    stat.ser_last  = n_r == SER_LAST;
    stat.pow_done  = 6'(j_r) == r_r[35:30];
    stat.clr_last  = clr_addr_r == AW'(DEPTH - 1);
    stat.out_free  = !out_valid_r || out_tready;
  end

endmodule

// ===== hw/rtl/igjh_ctrl.sv =====
// Controller: sequences clearing, accumulation, reads and the shade steps.
module igjh_ctrl
  import igjh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [1:0] in_tuser,
  input  stat_t      stat,
  output cmd_t       cmd
);

  ctl_state_t state_r, state_nxt;
  logic       from_op_r, from_op_nxt;
  logic       ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      from_op_r <= 1'b0;
      ph_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      from_op_r <= from_op_nxt;
      ph_r      <= ph_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt   = state_r;
    from_op_nxt = from_op_r;
    ph_nxt      = ph_r;
    cmd.op      = DP_NOP;
    cmd.sel     = ph_r;
    in_tready   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.op = DP_CLR_STEP;
        if (stat.clr_last) begin
          state_nxt = from_op_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_CLR_INIT: begin
        cmd.op      = DP_CLR_INIT;
        from_op_nxt = 1'b1;
        state_nxt   = ST_CLEAR;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = DP_LOAD;
          case (in_tuser)
            OP_ACCUM: state_nxt = ST_BIN_CHK;
            OP_READ:  state_nxt = ST_RD_ISSUE;
            OP_CLEAR: state_nxt = ST_CLR_INIT;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_BIN_CHK: begin
        if (stat.bin_ok) begin
          cmd.op    = DP_BIN_START;
          state_nxt = ST_BIN_WAIT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BIN_WAIT: begin
        if (!stat.bin_busy) begin
          cmd.op    = DP_ACC_RD;
          state_nxt = ST_ACC_UPD;
        end
      end
      ST_ACC_UPD: begin
        cmd.op    = DP_ACC_UPD;
        state_nxt = ST_DONE;
      end
      ST_RD_ISSUE: begin
        if (stat.rd_ok) begin
          cmd.op    = DP_RD_ISSUE;
          state_nxt = ST_RD_CAP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_CAP: begin
        cmd.op    = DP_RD_CAP;
        state_nxt = stat.m2_zero ? ST_DONE : ST_NORM_A;
      end
      // Normalize and take the log of the count, then of the runner-up.
      ST_NORM_A, ST_NORM_B: begin
        cmd.sel = state_r == ST_NORM_B;
        if (stat.norm_done) begin
          cmd.op    = DP_LOG_INIT;
          state_nxt = (state_r == ST_NORM_B) ? ST_LOG_B : ST_LOG_A;
        end else begin
          cmd.op = DP_NORM_STEP;
        end
      end
      ST_LOG_A, ST_LOG_B: begin
        cmd.op  = DP_LOG_STEP;
        cmd.sel = state_r == ST_LOG_B;
        if (stat.log_last) begin
          state_nxt = (state_r == ST_LOG_B) ? ST_RATIO_START : ST_LOAD_B;
        end
      end
      ST_LOAD_B: begin
        cmd.op    = DP_NORM_INIT_B;
        state_nxt = ST_NORM_B;
      end
      ST_RATIO_START: begin
        cmd.op    = DP_RATIO_START;
        state_nxt = ST_RATIO_WAIT;
      end
      ST_RATIO_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op    = DP_RATIO_CAP;
          state_nxt = ST_K_CHK;
        end
      end
      ST_K_CHK: begin
        if (stat.k_big) begin
          cmd.op    = DP_SHADE_SAT;
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = DP_SER_INIT;
          cmd.sel   = 1'b0;
          ph_nxt    = 1'b0;
          state_nxt = ST_SER_MUL;
        end
      end
      ST_SER_INIT_E: begin
        cmd.op    = DP_SER_INIT;
        cmd.sel   = 1'b1;
        ph_nxt    = 1'b1;
        state_nxt = ST_SER_MUL;
      end
      // One series term: multiply, divide by the term number, accumulate.
      ST_SER_MUL: begin
        cmd.op    = DP_SER_MUL;
        state_nxt = ST_SER_DIV;
      end
      ST_SER_DIV: begin
        cmd.op    = DP_SER_DIV;
        state_nxt = ST_SER_WAIT;
      end
      ST_SER_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op = DP_SER_ACC;
          if (!stat.ser_last) begin
            state_nxt = ST_SER_MUL;
          end else begin
            state_nxt = ph_r ? ST_POW : ST_SER_INIT_E;
          end
        end
      end
      ST_POW: begin
        if (stat.pow_done) begin
          cmd.op    = DP_FIN;
          state_nxt = ST_DONE;
        end else begin
          cmd.op = DP_POW_STEP;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.op      = DP_OUT_LOAD;
          from_op_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/intensity_gradient_joint_histogram.sv =====
// Top level of the intensity-gradient joint histogram.
//
// Input words arrive on in_tvalid/in_tready; in_tuser holds the kind
// (accumulate, read, clear) and in_tdata the sample and the bin to read.
// Every word gives one result word on out_tvalid/out_tready carrying the
// accepted flag, bin count, shade and current second-largest count.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
// One word is worked on at a time. An accumulate runs the bit-serial bin
// dividers and then the store read-modify-write; a dropped sample skips
// both. A read skips the shade steps when the runner-up count is zero;
// otherwise it makes two normalize-and-log passes, a ratio division and,
// unless the ratio is large, two 24-term series, all on the shared
// multiplier and divider. A clear writes one store entry per cycle. After
// reset the same clearing pass runs before the first word is taken. A
// finished result sits in an output register, so the next word is taken
// while it waits; a stalled receiver holds only the word after that.
module intensity_gradient_joint_histogram
  import igjh_pkg::*;
#(
  parameter int BINS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // intensity[15:0], gradient[31:16], read_gradient_bin[39:32],
  // read_intensity_bin[47:40]
  input  logic [47:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // accepted[0], bin_count[32:1], shade[40:33], second_max[72:41], zero fill
  output logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  igjh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .stat(stat), .cmd(cmd)
  );

  igjh_dp #(.BINS(BINS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_tdata(in_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule

// ===== sim/igjh_checker.sv =====
// Checker of the joint histogram: predicts each result word and compares it.
module igjh_checker
  import igjh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          pending_cnt,
  output int          fail_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = 256;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // Packed from the top bit down, so accepted lands in bit zero.
  typedef struct packed {
    logic [31:0] second_max;
    logic [7:0]  shade;
    logic [31:0] bin_count;
    logic        accepted;
  } hist_result_t;

  // Model copy of the store, the tracked maxima and the registers.
  logic [31:0]  hist [int];
  logic [31:0]  lead_count;
  logic [15:0]  lead_bin;
  logic [31:0]  runner_count;
  logic [15:0]  range_reg [4];
  hist_result_t result_q [$];

  // Exact bin of one sample; returns 0 when the sample is dropped.
  function automatic bit bin_index(longint v, longint lo, longint hi, output int idx);
    longint num, den;
    num = NBINS * (v - lo);
    den = hi - lo;
    idx = 0;
    if (den == 0) return 0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num < 0 || num >= NBINS * den) return 0;
    idx = int'(num / den);
    return 1;
  endfunction

  // log2 in Q24 by repeated squaring of the normalized mantissa.
  function automatic longint unsigned log2_fix(longint unsigned x);
    int msb;
    longint unsigned m, res;
    msb = 0;
    while (msb < 63 && (x >> (msb + 1)) != 0) msb++;
    m = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
    res = longint'(msb) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        res = res | (64'd1 << i);
      end
    end
    return res;
  endfunction

  // exp(-f) in Q30 by a 24-term truncated series.
  function automatic longint unsigned exp_decay(longint unsigned f);
    longint sum;
    longint unsigned term;
    sum = longint'(ONE_Q30);
    term = ONE_Q30;
    for (int n = 1; n <= 24; n++) begin
      term = ((term * f) >> 30) / n;
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  // Log-normalized grey level of a count against the runner-up count.
  function automatic logic [7:0] grey_level(logic [31:0] c, logic [31:0] m2);
    longint unsigned l1, l2, r, e, e1, v;
    int k;
    if (m2 == 0) return (c != 0) ? SHADE_FULL : 8'd0;
    l1 = log2_fix(longint'(c) + 1);
    l2 = log2_fix(longint'(m2) + 1);
    r = (l1 << 30) / l2;
    k = int'(r >> 30);
    if (k >= 6) return SHADE_FULL;
    e = exp_decay(r & (ONE_Q30 - 1));
    e1 = exp_decay(ONE_Q30);
    for (int j = 0; j < k; j++) e = (e * e1) >> 30;
    if (e >= ONE_Q30) return 8'd0;
    v = ((ONE_Q30 - e) << 8) >> 30;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [31:0] bin_value(int b);
    return hist.exists(b) ? hist[b] : 32'd0;
  endfunction

  // Apply one input word to the model and return its result.
  function automatic hist_result_t histogram_step(logic [1:0] op, logic [47:0] d);
    hist_result_t r;
    int ib, gb, b;
    bit iok, gok;
    logic [31:0] c;
    r = '0;
    if (op == OP_ACCUM) begin
      iok = bin_index(longint'($signed(d[15:0])), longint'($signed(range_reg[REG_INT_MIN])),
                      longint'($signed(range_reg[REG_INT_MAX])), ib);
      gok = bin_index(longint'(d[31:16]), longint'(range_reg[REG_GRAD_MIN]),
                      longint'(range_reg[REG_GRAD_MAX]), gb);
      if (iok && gok) begin
        b = gb * NBINS + ib;
        c = bin_value(b);
        r.accepted = 1'b1;
        if (c != 32'hFFFF_FFFF) begin
          c = c + 1;
          hist[b] = c;
          if (b == int'(lead_bin)) begin
            lead_count = c;
          end else if (c > lead_count) begin
            runner_count = lead_count;
            lead_count = c;
            lead_bin = b[15:0];
          end else if (c > runner_count) begin
            runner_count = c;
          end
        end
      end
    end else if (op == OP_READ) begin
      c = bin_value(int'(d[39:32]) * NBINS + int'(d[47:40]));
      r.bin_count = c;
      r.shade = grey_level(c, runner_count);
    end else if (op == OP_CLEAR) begin
      hist.delete();
      lead_count = 0;
      lead_bin = 0;
      runner_count = 0;
    end
    r.second_max = runner_count;
    return r;
  endfunction

  // Watch the register port and both channels at every edge.
  always @(posedge clk) begin
    hist_result_t want, got;
    if (!rst_n) begin
      hist.delete();
      lead_count = 0;
      lead_bin = 0;
      runner_count = 0;
      range_reg[REG_INT_MIN] = 16'd0;
      range_reg[REG_INT_MAX] = 16'd32767;
      range_reg[REG_GRAD_MIN] = 16'd0;
      range_reg[REG_GRAD_MAX] = 16'd65535;
      result_q.delete();
    end else begin
      if (cfg_we) range_reg[cfg_index] = cfg_wdata;
      if (in_tvalid && in_tready) result_q = {result_q, histogram_step(in_tuser, in_tdata)};
      if (out_tvalid && out_tready) begin
        got = out_tdata[72:0];
        if (result_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result word %h", out_tdata);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: accepted %0d/%0d count %0d/%0d shade %0d/%0d m2 %0d/%0d",
                       want.accepted, got.accepted, want.bin_count, got.bin_count,
                       want.shade, got.shade, want.second_max, got.second_max);
          end
        end
      end
    end
    pending_cnt <= result_q.size();
  end
endmodule

// ===== sim/intensity_gradient_joint_histogram_tb.sv =====
// Testbench top: stimulus, idling, register phases and the verdict.
module intensity_gradient_joint_histogram_tb
  import igjh_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 20_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  int          pending_cnt;
  int          fail_cnt;
  int          send_gap_pct;
  int          stall_pct;
  bit          long_hold;
  int          hold_cycles;
  longint      cycle_cnt;

  intensity_gradient_joint_histogram uut (.*);

  igjh_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (long_hold && hold_cycles < 400) begin
      hold_cycles <= hold_cycles + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one word and hold it until the block takes it.
  task automatic send_word(logic [1:0] op, logic [15:0] iv, logic [15:0] gv,
                           logic [7:0] gb, logic [7:0] ib);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {ib, gb, gv, iv};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every expected result has come.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes; the caller drops it.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_ranges(logic [15:0] imin, logic [15:0] imax,
                            logic [15:0] gmin, logic [15:0] gmax);
    drain();
    write_reg(REG_INT_MIN, imin);
    write_reg(REG_INT_MAX, imax);
    write_reg(REG_GRAD_MIN, gmin);
    write_reg(REG_GRAD_MAX, gmax);
    cfg_we <= 1'b0;
  endtask

  // One random phase. Ranges are chosen so a small pool of hot voxels
  // lands on known bins; wide values are mostly dropped as noise.
  task automatic random_phase(int n, int focus_pct, bit with_clear);
    logic [15:0] hot_i [4];
    logic [15:0] hot_g [4];
    int k, sel;
    for (k = 0; k < 4; k++) begin
      hot_i[k] = 16'($urandom_range(1, 255));
      hot_g[k] = 16'($urandom_range(0, 255));
    end
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (with_clear && k == n / 2) begin
        send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 70) begin
        if ($urandom_range(99) < focus_pct)
          send_word(OP_ACCUM, hot_i[0], hot_g[0], 8'($urandom), 8'($urandom));
        else if ($urandom_range(99) < 60)
          send_word(OP_ACCUM, hot_i[$urandom_range(1, 3)], hot_g[$urandom_range(1, 3)],
                    8'($urandom), 8'($urandom));
        else
          send_word(OP_ACCUM, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      end else if (sel < 98) begin
        if ($urandom_range(1) == 1)
          send_word(OP_READ, 16'($urandom), 16'($urandom),
                    hot_g[$urandom_range(3)][7:0], hot_i[$urandom_range(3)][7:0]);
        else
          send_word(OP_READ, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_word(OP_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_ACCUM;
    cfg_we = 1'b0;
    cfg_index = REG_INT_MIN;
    cfg_wdata = '0;
    send_gap_pct = 0;
    stall_pct = 0;
    long_hold = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset ranges: edges of both axes.
    send_word(OP_ACCUM, 16'd0, 16'd0, 8'd0, 8'd0);
    send_word(OP_ACCUM, 16'd0, 16'd0, 8'd0, 8'd0);
    send_word(OP_ACCUM, 16'd32767, 16'd5, 8'd0, 8'd0);
    send_word(OP_ACCUM, 16'hFFFF, 16'd5, 8'd0, 8'd0);
    send_word(OP_ACCUM, 16'd32766, 16'd65534, 8'd0, 8'd0);
    send_word(OP_ACCUM, 16'd100, 16'd65535, 8'd0, 8'd0);
    send_word(OP_READ, 16'd0, 16'd0, 8'd0, 8'd0);
    send_word(OP_READ, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255);
    send_word(OP_READ, 16'd0, 16'd0, 8'd1, 8'd1);
    send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    send_word(OP_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0);
    send_word(OP_READ, 16'd0, 16'd0, 8'd0, 8'd0);
    // Zero intensity span drops every sample.
    set_ranges(16'd5, 16'd5, 16'd0, 16'd256);
    send_word(OP_ACCUM, 16'd5, 16'd3, 8'd0, 8'd0);
    // Reversed span: bins run backwards between max and min.
    set_ranges(16'd100, 16'hFF9C, 16'd300, 16'd44);
    send_word(OP_ACCUM, 16'd0, 16'd100, 8'd0, 8'd0);
    send_word(OP_ACCUM, 16'd99, 16'd299, 8'd0, 8'd0);
    send_word(OP_ACCUM, 16'd100, 16'd44, 8'd0, 8'd0);
    send_word(OP_ACCUM, 16'hFF9C, 16'd300, 8'd0, 8'd0);
    send_word(OP_READ, 16'd0, 16'd0, 8'd128, 8'd128);
    send_word(OP_READ, 16'd0, 16'd0, 8'd0, 8'd1);

    // Identity mapping, one dominant bin: large ratios. Long receiver hold.
    set_ranges(16'd0, 16'd256, 16'd0, 16'd256);
    long_hold = 1'b1;
    random_phase(230, 90, 1'b0);
    // Sender gaps, reversed intensity axis, spread pool.
    set_ranges(16'd256, 16'd0, 16'd0, 16'd256);
    send_gap_pct = 50;
    random_phase(220, 30, 1'b1);
    // Receiver stalls, identity mapping again.
    set_ranges(16'd0, 16'd256, 16'd0, 16'd256);
    send_gap_pct = 0;
    stall_pct = 50;
    random_phase(220, 40, 1'b0);
    // Both idle, full-scale extremes on both axes.
    set_ranges(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF);
    send_gap_pct = 21;
    stall_pct = 21;
    random_phase(220, 50, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/igjh_pkg.sv
hw/rtl/igjh_ram.sv
hw/rtl/igjh_div.sv
hw/rtl/igjh_dp.sv
hw/rtl/igjh_ctrl.sv
hw/rtl/intensity_gradient_joint_histogram.sv
sim/igjh_checker.sv
sim/intensity_gradient_joint_histogram_tb.sv
